FILE: rtl/core/dgnhp_pkg.sv
`default_nettype none

package dgnhp_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int POS_BITS    = 18;
    localparam int SIZE_BITS   = 18;

    localparam logic [POS_BITS-1:0] POS_FIRST     = POS_BITS'(0);
    localparam logic [POS_BITS-1:0] POS_SECOND    = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_WORDS_LO  = POS_BITS'(2);
    localparam logic [POS_BITS-1:0] POS_WORDS_HI  = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_GROUP_LO  = POS_BITS'(28);
    localparam logic [POS_BITS-1:0] POS_GROUP_HI  = POS_BITS'(29);
    localparam logic [POS_BITS-1:0] POS_PROPS_LO  = POS_BITS'(32);
    localparam logic [POS_BITS-1:0] POS_PROPS_HI  = POS_BITS'(33);
    localparam logic [POS_BITS-1:0] POS_SYMBOLOGY = POS_BITS'(34);
    localparam logic [POS_BITS-1:0] POS_COLOR     = POS_BITS'(35);

    localparam logic [SIZE_BITS-1:0] HEADER_BYTES  = SIZE_BITS'(4);
    localparam logic [SIZE_BITS-1:0] DISPLAY_BYTES = SIZE_BITS'(36);
    localparam logic [7:0]           MARKER_BYTE   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_ELEMENT   = 2'd0,
        KIND_END       = 2'd1,
        KIND_TRUNCATED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t          report_kind;
        logic [6:0]     element_type;
        logic [5:0]     level_number;
        logic           complex_bit;
        logic           deleted_flag;
        logic [17:0]    element_bytes;
        logic [31:0]    element_offset;
        logic [15:0]    group_number;
        logic [15:0]    property_bits;
        logic [2:0]     line_style;
        logic [4:0]     line_weight;
        logic [7:0]     color_index;
    } report_t;

    function automatic logic lacks_display(input logic [6:0] t);
        logic r;
        case (t) inside
            7'd0, 7'd1, 7'd9, 7'd10, 7'd32, 7'd44, 7'd48, 7'd49,
            7'd50, 7'd51, 7'd57, 7'd60, 7'd61, 7'd62, 7'd63: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dgnhp_parse.sv
`default_nettype none

module dgnhp_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output logic                   has_report,
    output dgnhp_pkg::report_t     report
);
    import dgnhp_pkg::*;

    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] file_reg, file_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [7:0]             first_reg, first_next;
    logic [7:0]             second_reg, second_next;
    logic [15:0]            words_reg, words_next;
    logic [15:0]            group_reg, group_next;
    logic [15:0]            props_reg, props_next;
    logic [7:0]             symb_reg, symb_next;
    logic [7:0]             color_reg, color_next;
    logic                   stopped_reg, stopped_next;

    logic [OFFSET_BITS-1:0] start_c;
    logic [7:0]             first_c, second_c, symb_c, color_c;
    logic [15:0]            words_c, group_c, props_c;
    logic [SIZE_BITS-1:0]   size;
    logic                   marker, complete, words_known, display, clear;

    always_comb
    begin
        start_c  = start_reg;
        first_c  = first_reg;
        second_c = second_reg;
        words_c  = words_reg;
        group_c  = group_reg;
        props_c  = props_reg;
        symb_c   = symb_reg;
        color_c  = color_reg;
        case (pos_reg)
            POS_FIRST:
            begin
                start_c  = file_reg;
                first_c  = data_byte;
                second_c = 8'd0;
                words_c  = 16'd0;
                group_c  = 16'd0;
                props_c  = 16'd0;
                symb_c   = 8'd0;
                color_c  = 8'd0;
            end
            POS_SECOND:    second_c = data_byte;
            POS_WORDS_LO:  words_c  = {8'd0, data_byte};
            POS_WORDS_HI:  words_c  = {data_byte, words_reg[7:0]};
            POS_GROUP_LO:  group_c  = {8'd0, data_byte};
            POS_GROUP_HI:  group_c  = {data_byte, group_reg[7:0]};
            POS_PROPS_LO:  props_c  = {8'd0, data_byte};
            POS_PROPS_HI:  props_c  = {data_byte, props_reg[7:0]};
            POS_SYMBOLOGY: symb_c   = data_byte;
            POS_COLOR:     color_c  = data_byte;
            default:       ;
        endcase

        size        = {1'b0, words_c, 1'b0} + HEADER_BYTES;
        words_known = (pos_reg >= POS_WORDS_HI);
        marker      = (pos_reg == POS_SECOND) && (first_reg == MARKER_BYTE)
                      && (data_byte == MARKER_BYTE);
        complete    = words_known && ((pos_reg + POS_BITS'(1)) == size);
        display     = !lacks_display(second_c[6:0]) && (size >= DISPLAY_BYTES);

        report.element_type   = second_c[6:0];
        report.level_number   = first_c[5:0];
        report.complex_bit    = first_c[7];
        report.deleted_flag   = second_c[7];
        report.element_offset = 32'(start_c);
        report.group_number   = 16'd0;
        report.property_bits  = 16'd0;
        report.line_style     = 3'd0;
        report.line_weight    = 5'd0;
        report.color_index    = 8'd0;
        if (marker)
        begin
            report.report_kind   = KIND_END;
            report.element_bytes = 18'd0;
        end
        else if (complete)
        begin
            report.report_kind   = KIND_ELEMENT;
            report.element_bytes = size;
            if (display)
            begin
                report.group_number  = group_c;
                report.property_bits = props_c;
                report.line_style    = symb_c[2:0];
                report.line_weight   = symb_c[7:3];
                report.color_index   = color_c;
            end
        end
        else
        begin
            report.report_kind   = KIND_TRUNCATED;
            report.element_bytes = words_known ? size : 18'd0;
        end

        has_report   = 1'b0;
        clear        = 1'b0;
        pos_next     = pos_reg;
        file_next    = file_reg;
        start_next   = start_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        words_next   = words_reg;
        group_next   = group_reg;
        props_next   = props_reg;
        symb_next    = symb_reg;
        color_next   = color_reg;
        stopped_next = stopped_reg;

        if (take)
        begin
            if (stopped_reg)
            begin
                clear = last_byte;
            end
            else
            begin
                file_next   = file_reg + OFFSET_BITS'(1);
                start_next  = start_c;
                first_next  = first_c;
                second_next = second_c;
                words_next  = words_c;
                group_next  = group_c;
                props_next  = props_c;
                symb_next   = symb_c;
                color_next  = color_c;
                if (marker)
                begin
                    has_report   = 1'b1;
                    clear        = last_byte;
                    stopped_next = 1'b1;
                end
                else if (complete)
                begin
                    has_report = 1'b1;
                    clear      = last_byte;
                    pos_next   = POS_FIRST;
                end
                else if (last_byte)
                begin
                    has_report = 1'b1;
                    clear      = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_BITS'(1);
                end
            end
        end

        if (clear)
        begin
            pos_next     = '0;
            file_next    = '0;
            start_next   = '0;
            first_next   = '0;
            second_next  = '0;
            words_next   = '0;
            group_next   = '0;
            props_next   = '0;
            symb_next    = '0;
            color_next   = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            file_reg    <= '0;
            start_reg   <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            words_reg   <= '0;
            group_reg   <= '0;
            props_reg   <= '0;
            symb_reg    <= '0;
            color_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            file_reg    <= file_next;
            start_reg   <= start_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            words_reg   <= words_next;
            group_reg   <= group_next;
            props_reg   <= props_next;
            symb_reg    <= symb_next;
            color_reg   <= color_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dgnhp_skid.sv
`default_nettype none

module dgnhp_skid (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dgnhp_pkg::report_t push_data,
    output logic                   space,
    output logic                   report_valid,
    input  wire logic              report_ready,
    output dgnhp_pkg::report_t     report
);
    import dgnhp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    report_t main_reg, main_next;
    report_t skid_reg, skid_next;
    logic    pop;

    assign space        = !skid_valid_reg;
    assign report_valid = main_valid_reg;
    assign report       = main_reg;
    assign pop          = main_valid_reg && report_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/dgn_element_header_parser_unit.sv
// Channel   Handshake                    Beat
// byte      byte_valid / byte_ready      data_byte, last_byte
// report    report_valid / report_ready  report_kind .. color_index
//
// One byte beat per cycle while byte_ready is high; each report is registered.
// Rate is set by the header capture and the size compare, one pass per byte.
// Reports wait in a two-entry output buffer; byte_ready drops only when both are full.
// Reset clears the byte counters and header fields at once; no clearing pass.
`default_nettype none

module dgn_element_header_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             report_valid,
    input  wire logic        report_ready,
    output logic [1:0]       report_kind,
    output logic [6:0]       element_type,
    output logic [5:0]       level_number,
    output logic             complex_bit,
    output logic             deleted_flag,
    output logic [17:0]      element_bytes,
    output logic [31:0]      element_offset,
    output logic [15:0]      group_number,
    output logic [15:0]      property_bits,
    output logic [2:0]       line_style,
    output logic [4:0]       line_weight,
    output logic [7:0]       color_index
);
    import dgnhp_pkg::*;

    logic    take;
    logic    has_report;
    logic    space;
    report_t parsed;
    report_t held;

    assign byte_ready = space;
    assign take       = byte_valid && space;

    dgnhp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .has_report (has_report),
        .report     (parsed)
    );

    dgnhp_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (has_report),
        .push_data    (parsed),
        .space        (space),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (held)
    );

    assign report_kind    = held.report_kind;
    assign element_type   = held.element_type;
    assign level_number   = held.level_number;
    assign complex_bit    = held.complex_bit;
    assign deleted_flag   = held.deleted_flag;
    assign element_bytes  = held.element_bytes;
    assign element_offset = held.element_offset;
    assign group_number   = held.group_number;
    assign property_bits  = held.property_bits;
    assign line_style     = held.line_style;
    assign line_weight    = held.line_weight;
    assign color_index    = held.color_index;

endmodule

`default_nettype wire
